// ===== rtl/nmns_pkg.sv =====
// ----------------------------------------------------------------------------
// nmns_pkg: shared constants for the neighbour mean noise smoother
// Default sizes, configuration register indexes and fixed arithmetic
// constants used by the smoother and its window cells.
// ----------------------------------------------------------------------------
package nmns_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 128;
  localparam int DEF_PIXEL_BITS  = 8;

  // Configuration port geometry.
  localparam int CFG_DATA_BITS  = 8;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COLUMN_COUNT    = 2'd0,
    REG_ROW_COUNT       = 2'd1,
    REG_NOISE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Reset values of the registers and the smallest legal frame dimension.
  localparam int DIM_RESET       = 128;
  localparam int MIN_DIM         = 3;
  localparam int THRESHOLD_RESET = 2;

  // Eight neighbours: the mean is a right shift by three.
  localparam int NEIGHBOUR_SHIFT = 3;

  // Stored window columns: the two columns left of the incoming one.
  localparam int WINDOW_CELLS = 2;

endpackage

// ===== rtl/nmns_ram.sv =====
// ----------------------------------------------------------------------------
// nmns_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read that updates
// only when the read enable is high.
// ----------------------------------------------------------------------------
module nmns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nmns_col_cell.sv =====
// ----------------------------------------------------------------------------
// nmns_col_cell: one column of the 3x3 window
// Holds the top, middle and bottom pixel of one window column, loads the
// column from its neighbor on every shift and presents its partial sums.
// ----------------------------------------------------------------------------
module nmns_col_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [PIXEL_BITS-1:0] in_top,
  input  logic [PIXEL_BITS-1:0] in_mid,
  input  logic [PIXEL_BITS-1:0] in_bot,
  output logic [PIXEL_BITS-1:0] top,
  output logic [PIXEL_BITS-1:0] mid,
  output logic [PIXEL_BITS-1:0] bot,
  output logic [PIXEL_BITS:0]   edge_sum,
  output logic [PIXEL_BITS+1:0] col_sum
);

  // Column storage, loaded from the neighbor on each shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      top <= in_top;
      mid <= in_mid;
      bot <= in_bot;
    end
  end

  // Top plus bottom serves a column whose middle is the centre pixel.
  assign edge_sum = (PIXEL_BITS+1)'(top) + (PIXEL_BITS+1)'(bot);
  assign col_sum  = (PIXEL_BITS+2)'(edge_sum) + (PIXEL_BITS+2)'(mid);

endmodule

// ===== rtl/neighbour_mean_noise_smooth_top.sv =====
// ----------------------------------------------------------------------------
// neighbour_mean_noise_smooth_top: 3x3 neighbour mean smoother with noise flag
// Streams a raster frame, keeps two line stores and a window of column cells,
// and emits the truncated mean of the eight neighbours of each interior pixel.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle in row-major order while
// in_stall is low, and gives one result for each pixel at row 2 or more
// and column 2 or more: the line store is read as the pixel is accepted
// into the read stage, the sum stage registers the window sum, and the
// mean and noise compare feed the output register. The two previous rows
// live in a single memory with one read and one write port,
// read for the incoming column and written back as the column leaves the
// read stage, so each pixel costs one memory access of each kind. No
// clearing pass runs after reset; line store entries are only seen once
// written. Writing column_count or row_count restarts the frame at row 0,
// column 0; configure only while no transaction is in flight.
module neighbour_mean_noise_smooth_top
  import nmns_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]    cfg_data,
  // Pixel input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [PIXEL_BITS-1:0]       pixel_value,
  // Result output channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [PIXEL_BITS-1:0]       smoothed_value,
  output logic                        noise_flag,
  output logic [$clog2(MAX_ROWS)-1:0]    centre_row,
  output logic [$clog2(MAX_COLUMNS)-1:0] centre_column,
  output logic                        frame_last
);

  localparam int COL_BITS = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS = $clog2(MAX_ROWS);
  localparam int CC_BITS  = $clog2(MAX_COLUMNS + 1);
  localparam int RC_BITS  = $clog2(MAX_ROWS + 1);
  localparam int CCW      = (CC_BITS > CFG_DATA_BITS) ? CC_BITS : CFG_DATA_BITS;
  localparam int RCW      = (RC_BITS > CFG_DATA_BITS) ? RC_BITS : CFG_DATA_BITS;
  localparam int TW       = (PIXEL_BITS > CFG_DATA_BITS) ? PIXEL_BITS : CFG_DATA_BITS;
  localparam int SUM_BITS = PIXEL_BITS + NEIGHBOUR_SHIFT;
  localparam int COL_RESET = (DIM_RESET > MAX_COLUMNS) ? MAX_COLUMNS : DIM_RESET;
  localparam int ROW_RESET = (DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET;

  // Configuration registers.
  logic [CC_BITS-1:0]       column_count;
  logic [RC_BITS-1:0]       row_count;
  logic [CFG_DATA_BITS-1:0] noise_threshold;

  // Position of the next pixel.
  logic [COL_BITS-1:0] col_pos;
  logic [ROW_BITS-1:0] row_pos;

  // Read stage.
  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_px;
  logic [COL_BITS-1:0]   s1_col;
  logic [ROW_BITS-1:0]   s1_row;

  // Sum stage.
  logic                  s2_valid;
  logic [SUM_BITS-1:0]   s2_sum;
  logic [PIXEL_BITS-1:0] s2_centre;
  logic [ROW_BITS-1:0]   s2_row;
  logic [COL_BITS-1:0]   s2_col;
  logic                  s2_last;

  // Handshake and stage transfer controls.
  logic in_accept;
  logic out_ready;
  logic s2_ready;
  logic s1_ready;
  logic t1;
  logic t2;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && !in_stall;
  assign t1        = s1_valid && s2_ready;
  assign t2        = s2_valid && out_ready;

  // Dimension clamping of configuration writes.
  logic [CCW-1:0]     col_wide;
  logic [RCW-1:0]     row_wide;
  logic [CC_BITS-1:0] col_clamped;
  logic [RC_BITS-1:0] row_clamped;

  always_comb begin
    col_wide = CCW'(cfg_data);
    row_wide = RCW'(cfg_data);
    if (col_wide < CCW'(MIN_DIM)) begin
      col_clamped = CC_BITS'(MIN_DIM);
    end else if (col_wide > CCW'(MAX_COLUMNS)) begin
      col_clamped = CC_BITS'(MAX_COLUMNS);
    end else begin
      col_clamped = CC_BITS'(col_wide);
    end
    if (row_wide < RCW'(MIN_DIM)) begin
      row_clamped = RC_BITS'(MIN_DIM);
    end else if (row_wide > RCW'(MAX_ROWS)) begin
      row_clamped = RC_BITS'(MAX_ROWS);
    end else begin
      row_clamped = RC_BITS'(row_wide);
    end
  end

  // Raster position stepping.
  logic               col_wrap;
  logic               row_wrap;
  logic [COL_BITS-1:0] col_pos_next;
  logic [ROW_BITS-1:0] row_pos_next;

  always_comb begin
    col_wrap = (CC_BITS'(col_pos) + CC_BITS'(1)) >= column_count;
    row_wrap = (RC_BITS'(row_pos) + RC_BITS'(1)) >= row_count;
    if (col_wrap) begin
      col_pos_next = '0;
      row_pos_next = row_wrap ? '0 : row_pos + ROW_BITS'(1);
    end else begin
      col_pos_next = col_pos + COL_BITS'(1);
      row_pos_next = row_pos;
    end
  end

  // Configuration registers and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= CC_BITS'(COL_RESET);
      row_count       <= RC_BITS'(ROW_RESET);
      noise_threshold <= CFG_DATA_BITS'(THRESHOLD_RESET);
      col_pos         <= '0;
      row_pos         <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLUMN_COUNT: begin
          column_count <= col_clamped;
          col_pos      <= '0;
          row_pos      <= '0;
        end
        REG_ROW_COUNT: begin
          row_count <= row_clamped;
          col_pos   <= '0;
          row_pos   <= '0;
        end
        REG_NOISE_THRESHOLD: begin
          noise_threshold <= cfg_data;
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Line stores: upper row in the high half, middle row in the low half.
  logic [2*PIXEL_BITS-1:0] line_rd;
  logic [PIXEL_BITS-1:0]   line_top;
  logic [PIXEL_BITS-1:0]   line_mid;

  assign line_top = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign line_mid = line_rd[PIXEL_BITS-1:0];

  nmns_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (t1),
    .wr_addr (s1_col),
    .wr_data ({line_mid, s1_px}),
    .rd_en   (in_accept),
    .rd_addr (col_pos),
    .rd_data (line_rd)
  );

  // Read stage registers, loaded alongside the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (t1) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px  <= pixel_value;
      s1_col <= col_pos;
      s1_row <= row_pos;
    end
  end

  // Window cells: cell 0 holds column c-1, cell 1 holds column c-2.
  logic [PIXEL_BITS-1:0] cell_in_top [WINDOW_CELLS];
  logic [PIXEL_BITS-1:0] cell_in_mid [WINDOW_CELLS];
  logic [PIXEL_BITS-1:0] cell_in_bot [WINDOW_CELLS];
  logic [PIXEL_BITS-1:0] cell_top    [WINDOW_CELLS];
  logic [PIXEL_BITS-1:0] cell_mid    [WINDOW_CELLS];
  logic [PIXEL_BITS-1:0] cell_bot    [WINDOW_CELLS];
  logic [PIXEL_BITS:0]   cell_edge   [WINDOW_CELLS];
  logic [PIXEL_BITS+1:0] cell_col    [WINDOW_CELLS];

  for (genvar i = 0; i < WINDOW_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in_top[i] = line_top;
      assign cell_in_mid[i] = line_mid;
      assign cell_in_bot[i] = s1_px;
    end else begin : g_link
      assign cell_in_top[i] = cell_top[i-1];
      assign cell_in_mid[i] = cell_mid[i-1];
      assign cell_in_bot[i] = cell_bot[i-1];
    end

    nmns_col_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk      (clk),
      .shift    (t1),
      .in_top   (cell_in_top[i]),
      .in_mid   (cell_in_mid[i]),
      .in_bot   (cell_in_bot[i]),
      .top      (cell_top[i]),
      .mid      (cell_mid[i]),
      .bot      (cell_bot[i]),
      .edge_sum (cell_edge[i]),
      .col_sum  (cell_col[i])
    );
  end

  // Neighbour sum: full left column, centre column without its middle,
  // and the incoming column.
  logic [SUM_BITS-1:0] sum_next;
  logic                interior;
  logic                last_next;

  always_comb begin
    sum_next = SUM_BITS'(cell_col[WINDOW_CELLS-1]) + SUM_BITS'(cell_edge[0])
             + SUM_BITS'(line_top) + SUM_BITS'(line_mid) + SUM_BITS'(s1_px);
    interior = (s1_row >= ROW_BITS'(2)) && (s1_col >= COL_BITS'(2));
    last_next = ((RC_BITS'(s1_row) + RC_BITS'(1)) == row_count)
             && ((CC_BITS'(s1_col) + CC_BITS'(1)) == column_count);
  end

  // Sum stage; border pixels leave no transaction behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (t1) begin
      s2_valid <= interior;
    end else if (t2) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (t1) begin
      s2_sum    <= sum_next;
      s2_centre <= cell_mid[0];
      s2_row    <= s1_row - ROW_BITS'(1);
      s2_col    <= s1_col - COL_BITS'(1);
      s2_last   <= last_next;
    end
  end

  // Mean and noise decision.
  logic [PIXEL_BITS-1:0] mean;
  logic [PIXEL_BITS-1:0] diff;
  logic                  flag_next;

  always_comb begin
    mean = s2_sum[SUM_BITS-1:NEIGHBOUR_SHIFT];
    diff = (s2_centre >= mean) ? (s2_centre - mean) : (mean - s2_centre);
    flag_next = TW'(diff) >= TW'(noise_threshold);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (t2) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (t2) begin
      smoothed_value <= mean;
      noise_flag     <= flag_next;
      centre_row     <= s2_row;
      centre_column  <= s2_col;
      frame_last     <= s2_last;
    end
  end

`ifndef SYNTHESIS
  // The raster position always stays inside the configured frame.
  assert property (@(posedge clk) disable iff (rst)
    (CC_BITS'(col_pos) < column_count) && (RC_BITS'(row_pos) < row_count))
    else $error("raster position outside the configured frame");

  // Results only ever come from interior centres.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (centre_row != '0) && (centre_column != '0))
    else $error("result for a border pixel");

  // The last result of a frame sits one column left of the final column.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |->
      (CC_BITS'(centre_column) + CC_BITS'(2)) == column_count)
    else $error("frame end flagged at the wrong column");
`endif

endmodule
